[hdl/hrp_pkg.sv]
// hrp_pkg: shared types, character codes and character-class functions
// for the http request head parser; no dependencies
package hrp_pkg;

  localparam int VERSION_WIDTH_DEF = 8;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CLASS_W  = 3;

  typedef enum logic [4:0] {
    S_METHOD_START, S_METHOD, S_URI, S_VER_H, S_VER_T1, S_VER_T2, S_VER_P,
    S_VER_SLASH, S_MAJ_START, S_MAJ, S_MIN_START, S_MIN, S_NL1,
    S_LINE_START, S_LWS, S_NAME, S_SP_VALUE, S_VALUE, S_NL2, S_NL3
  } parse_state_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MORE = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [CLASS_W-1:0] {
    C_DELIM   = 3'd0,
    C_METHOD  = 3'd1,
    C_URI     = 3'd2,
    C_NEWNAME = 3'd3,
    C_NAME    = 3'd4,
    C_VALUE   = 3'd5
  } byte_class_t;

  typedef enum logic {
    ACT_BYTE    = 1'b0,
    ACT_RESTART = 1'b1
  } action_t;

  typedef struct packed {
    parse_state_t parse_state;
    logic         header_seen;
  } ctx_t;

  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CTL_MAX = 8'd31;
  localparam logic [7:0] CH_DEL     = 8'd127;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return (c <= CH_DEL) && !is_ctl(c) && !is_sep(c);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[hdl/hrp_step.sv]
// hrp_step: per-byte state transition, classification and version digit
// accumulation; combinational; depends on hrp_pkg
module hrp_step #(
  parameter int VERSION_WIDTH = hrp_pkg::VERSION_WIDTH_DEF
) (
  input  logic                       action,
  input  logic [7:0]                 data_byte,
  input  hrp_pkg::ctx_t              ctx,
  input  logic [VERSION_WIDTH-1:0]   major_acc,
  input  logic [VERSION_WIDTH-1:0]   minor_acc,
  output hrp_pkg::ctx_t              ctx_next,
  output logic [VERSION_WIDTH-1:0]   major_next,
  output logic [VERSION_WIDTH-1:0]   minor_next,
  output hrp_pkg::status_t           status,
  output hrp_pkg::byte_class_t       byte_class
);

  localparam int ACC_W = VERSION_WIDTH + 4;

  logic [ACC_W-1:0]         maj_wide;
  logic [ACC_W-1:0]         min_wide;
  logic [VERSION_WIDTH-1:0] maj_dig;
  logic [VERSION_WIDTH-1:0] min_dig;
  logic [ACC_W-1:0]         digit;
  logic [7:0]               c;
  logic                     ws;

  assign c     = data_byte;
  assign ws    = (c == hrp_pkg::CH_SP) || (c == hrp_pkg::CH_HT);
  assign digit = {{(ACC_W-4){1'b0}}, c[3:0]};

  // acc * 10 + digit, saturating
  assign maj_wide = ({4'b0, major_acc} << 3) + ({4'b0, major_acc} << 1) + digit;
  assign min_wide = ({4'b0, minor_acc} << 3) + ({4'b0, minor_acc} << 1) + digit;
  assign maj_dig  = (maj_wide[ACC_W-1:VERSION_WIDTH] != 4'b0) ?
                    {VERSION_WIDTH{1'b1}} : maj_wide[VERSION_WIDTH-1:0];
  assign min_dig  = (min_wide[ACC_W-1:VERSION_WIDTH] != 4'b0) ?
                    {VERSION_WIDTH{1'b1}} : min_wide[VERSION_WIDTH-1:0];

  always_comb begin
    hrp_pkg::parse_state_t    ns;
    logic                     hs;
    logic [VERSION_WIDTH-1:0] maj;
    logic [VERSION_WIDTH-1:0] mnr;
    hrp_pkg::status_t         st;
    hrp_pkg::byte_class_t     cls;

    ns  = ctx.parse_state;
    hs  = ctx.header_seen;
    maj = major_acc;
    mnr = minor_acc;
    st  = hrp_pkg::ST_MORE;
    cls = hrp_pkg::C_DELIM;

    case (ctx.parse_state)
      hrp_pkg::S_METHOD_START: begin
        if (hrp_pkg::is_token(c)) begin
          ns  = hrp_pkg::S_METHOD;
          cls = hrp_pkg::C_METHOD;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_METHOD: begin
        if (c == hrp_pkg::CH_SP) ns = hrp_pkg::S_URI;
        else if (hrp_pkg::is_token(c)) cls = hrp_pkg::C_METHOD;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_URI: begin
        if (c == hrp_pkg::CH_SP) ns = hrp_pkg::S_VER_H;
        else if (hrp_pkg::is_ctl(c)) st = hrp_pkg::ST_BAD;
        else cls = hrp_pkg::C_URI;
      end
      hrp_pkg::S_VER_H: begin
        if (c == hrp_pkg::CH_H) ns = hrp_pkg::S_VER_T1;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_T1: begin
        if (c == hrp_pkg::CH_T) ns = hrp_pkg::S_VER_T2;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_T2: begin
        if (c == hrp_pkg::CH_T) ns = hrp_pkg::S_VER_P;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_P: begin
        if (c == hrp_pkg::CH_P) ns = hrp_pkg::S_VER_SLASH;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VER_SLASH: begin
        if (c == hrp_pkg::CH_SLASH) begin
          maj = '0;
          mnr = '0;
          ns  = hrp_pkg::S_MAJ_START;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MAJ_START: begin
        if (hrp_pkg::is_digit(c)) begin
          maj = maj_dig;
          ns  = hrp_pkg::S_MAJ;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MAJ: begin
        if (c == hrp_pkg::CH_DOT) ns = hrp_pkg::S_MIN_START;
        else if (hrp_pkg::is_digit(c)) maj = maj_dig;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MIN_START: begin
        if (hrp_pkg::is_digit(c)) begin
          mnr = min_dig;
          ns  = hrp_pkg::S_MIN;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_MIN: begin
        if (c == hrp_pkg::CH_CR) ns = hrp_pkg::S_NL1;
        else if (hrp_pkg::is_digit(c)) mnr = min_dig;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_NL1: begin
        if (c == hrp_pkg::CH_LF) ns = hrp_pkg::S_LINE_START;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LINE_START: begin
        if (c == hrp_pkg::CH_CR) ns = hrp_pkg::S_NL3;
        else if (ctx.header_seen && ws) ns = hrp_pkg::S_LWS;
        else if (hrp_pkg::is_token(c)) begin
          hs  = 1'b1;
          ns  = hrp_pkg::S_NAME;
          cls = hrp_pkg::C_NEWNAME;
        end else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_LWS: begin
        if (c == hrp_pkg::CH_CR) ns = hrp_pkg::S_NL2;
        else if (ws) ns = hrp_pkg::S_LWS;
        else if (hrp_pkg::is_ctl(c)) st = hrp_pkg::ST_BAD;
        else begin
          ns  = hrp_pkg::S_VALUE;
          cls = hrp_pkg::C_VALUE;
        end
      end
      hrp_pkg::S_NAME: begin
        if (c == hrp_pkg::CH_COLON) ns = hrp_pkg::S_SP_VALUE;
        else if (hrp_pkg::is_token(c)) cls = hrp_pkg::C_NAME;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_SP_VALUE: begin
        if (c == hrp_pkg::CH_SP) ns = hrp_pkg::S_VALUE;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_VALUE: begin
        if (c == hrp_pkg::CH_CR) ns = hrp_pkg::S_NL2;
        else if (hrp_pkg::is_ctl(c)) st = hrp_pkg::ST_BAD;
        else cls = hrp_pkg::C_VALUE;
      end
      hrp_pkg::S_NL2: begin
        if (c == hrp_pkg::CH_LF) ns = hrp_pkg::S_LINE_START;
        else st = hrp_pkg::ST_BAD;
      end
      hrp_pkg::S_NL3: begin
        st = (c == hrp_pkg::CH_LF) ? hrp_pkg::ST_GOOD : hrp_pkg::ST_BAD;
      end
      default: st = hrp_pkg::ST_BAD;
    endcase

    // bad byte leaves all state untouched
    if (st == hrp_pkg::ST_BAD) begin
      cls = hrp_pkg::C_DELIM;
      ns  = ctx.parse_state;
      hs  = ctx.header_seen;
      maj = major_acc;
      mnr = minor_acc;
    end

    if (action == hrp_pkg::ACT_RESTART) begin
      ns  = hrp_pkg::S_METHOD_START;
      hs  = 1'b0;
      maj = '0;
      mnr = '0;
      st  = hrp_pkg::ST_MORE;
      cls = hrp_pkg::C_DELIM;
    end

    ctx_next.parse_state = ns;
    ctx_next.header_seen = hs;
    major_next           = maj;
    minor_next           = mnr;
    status               = st;
    byte_class           = cls;
  end

endmodule

[hdl/http_request_head_parser.sv]
// http_request_head_parser: top level with input register, parser state and
// result register; depends on hrp_pkg and hrp_step
//
// Takes one request byte (or a restart) per cycle while the output side keeps
// up, and returns one result per byte: status, role of the byte, the byte
// itself and the version numbers accumulated so far. A transfer is registered
// on entry, runs through the combinational parser logic against the held
// parser state and lands in the result register once that register can take
// it. The input register and the output register each hold one item; when the
// output side stalls with the input register holding an item, the input side
// stalls in the same cycle, so at most two items wait inside the block.
module http_request_head_parser #(
  parameter int VERSION_WIDTH = hrp_pkg::VERSION_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [2:0]  byte_class,
  output logic [7:0]  byte_echo,
  output logic [7:0]  version_major,
  output logic [7:0]  version_minor
);

  logic                     in_full;
  logic                     action_q;
  logic [7:0]               byte_q;
  logic                     res_ready;
  logic                     advance;

  hrp_pkg::ctx_t            ctx;
  hrp_pkg::ctx_t            ctx_next;
  logic [VERSION_WIDTH-1:0] major_acc;
  logic [VERSION_WIDTH-1:0] minor_acc;
  logic [VERSION_WIDTH-1:0] major_next;
  logic [VERSION_WIDTH-1:0] minor_next;
  hrp_pkg::status_t         step_status;
  hrp_pkg::byte_class_t     step_class;
  logic [VERSION_WIDTH+7:0] major_ext;
  logic [VERSION_WIDTH+7:0] minor_ext;

  assign res_ready = !out_valid || !out_stall;
  assign advance   = in_full && res_ready;
  assign in_stall  = in_full && !res_ready;

  hrp_step #(
    .VERSION_WIDTH (VERSION_WIDTH)
  ) u_step (
    .action     (action_q),
    .data_byte  (byte_q),
    .ctx        (ctx),
    .major_acc  (major_acc),
    .minor_acc  (minor_acc),
    .ctx_next   (ctx_next),
    .major_next (major_next),
    .minor_next (minor_next),
    .status     (step_status),
    .byte_class (step_class)
  );

  assign major_ext = {8'b0, major_next};
  assign minor_ext = {8'b0, minor_next};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      action_q <= action;
      byte_q   <= data_byte;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx.parse_state <= hrp_pkg::S_METHOD_START;
      ctx.header_seen <= 1'b0;
      major_acc       <= '0;
      minor_acc       <= '0;
    end else if (advance) begin
      ctx       <= ctx_next;
      major_acc <= major_next;
      minor_acc <= minor_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= in_full;
    end
    if (advance) begin
      status        <= step_status;
      byte_class    <= step_class;
      byte_echo     <= (action_q == hrp_pkg::ACT_RESTART) ? 8'b0 : byte_q;
      version_major <= major_ext[7:0];
      version_minor <= minor_ext[7:0];
    end
  end

endmodule
